[hw/rtl/piel_pkg.sv]
// Shared types and constants for the positional insert/erase list.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package piel_pkg;

	localparam int CAPACITY = 64;
	localparam int WORD_W   = 32;
	localparam int POS_W    = 7;
	localparam int CNT_W    = 7;
	localparam int KIND_W   = 3;
	localparam int STAT_W   = 2;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int GROUP    = 8;
	localparam int NGRP     = (CAPACITY + GROUP - 1) / GROUP;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [POS_W-1:0]         pos_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [IDX_W-1:0]         idx_t;

	typedef enum logic [KIND_W-1:0] {
		K_APPEND = 3'd0,
		K_INSERT = 3'd1,
		K_REMOVE = 3'd2,
		K_ERASE  = 3'd3,
		K_READ   = 3'd4,
		K_CLEAR  = 3'd5
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// What every cell does at the next edge.
	typedef enum logic [1:0] {
		ACT_HOLD,
		ACT_LOAD,
		ACT_INSERT,
		ACT_ERASE
	} act_t;

	typedef struct packed {
		act_t  act;
		pos_t  pos;
		word_t val;
	} cell_ctl_t;

	// Which cell drives its word onto the gather tree.
	typedef struct packed {
		logic en;
		pos_t pos;
	} sel_t;

endpackage

`default_nettype wire

[hw/rtl/piel_cell.sv]
// One storage cell of the list: holds one word and trades it with its neighbors.
// Depends on piel_pkg for the control and select structs.
`default_nettype none

module piel_cell (
	input  wire                  clk,
	input  piel_pkg::idx_t       idx,
	input  piel_pkg::cell_ctl_t  ctl,
	input  piel_pkg::sel_t       sel,
	input  piel_pkg::word_t      left_word,
	input  piel_pkg::word_t      right_word,
	output piel_pkg::word_t      word,
	output piel_pkg::word_t      tap
);
	import piel_pkg::*;

	word_t word_q;
	pos_t  my_pos;

	assign my_pos = pos_t'(idx);
	assign word   = word_q;
	assign tap    = (sel.en && sel.pos == my_pos) ? word_q : '0;

	always_ff @(posedge clk) begin
		unique case (ctl.act)
			ACT_LOAD: begin
				if (my_pos == ctl.pos)
					word_q <= ctl.val;
			end
			ACT_INSERT: begin
				// move up above the slot, take the new word at it
				if (my_pos > ctl.pos)
					word_q <= left_word;
				else if (my_pos == ctl.pos)
					word_q <= ctl.val;
			end
			ACT_ERASE: begin
				if (my_pos >= ctl.pos)
					word_q <= right_word;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/piel_gather.sv]
// Registered OR tree that collects the single selected cell word.
// Depends on piel_pkg for word type and group sizing.
`default_nettype none

module piel_gather (
	input  wire              clk,
	input  piel_pkg::word_t  taps [piel_pkg::CAPACITY],
	output piel_pkg::word_t  word
);
	import piel_pkg::*;

	word_t grp_d [NGRP];
	word_t grp_q [NGRP];

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GROUP; k++) begin
				if (g * GROUP + k < CAPACITY)
					grp_d[g] = grp_d[g] | taps[g * GROUP + k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NGRP; g++)
			grp_q[g] <= grp_d[g];
	end

	always_comb begin
		word = '0;
		for (int g = 0; g < NGRP; g++)
			word = word | grp_q[g];
	end

endmodule

`default_nettype wire

[hw/rtl/positional_insert_erase_list.sv]
// Top level of the positional insert/erase list: control, cell row, gather tree.
// Depends on piel_pkg, piel_cell and piel_gather.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------
//  in      | in_valid / in_ready | kind, position, value
//  out     | out_valid/out_ready | status, read_value, entry_count, first_value,
//          |                     | last_value
//
// Per item, the cells shift at the accept edge and the gather tree registers
// the read word; S_READ captures it while the tree registers the last word;
// S_LAST loads the result. One item is in flight at a time; a new item is
// taken while the previous result still waits in the output register. A
// stalled output holds the block in its final state. Reset clears the count
// and the handshake state; the cell words stay undefined until written.
`default_nettype none

module positional_insert_erase_list (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire [piel_pkg::KIND_W-1:0]  kind,
	input  piel_pkg::pos_t              position,
	input  piel_pkg::word_t             value,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [piel_pkg::STAT_W-1:0] status,
	output piel_pkg::word_t             read_value,
	output piel_pkg::cnt_t              entry_count,
	output piel_pkg::word_t             first_value,
	output piel_pkg::word_t             last_value
);
	import piel_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_LAST
	} state_t;

	state_t    state_q;
	cnt_t      count_q;
	status_t   stat_q;
	word_t     read_q;
	logic      out_valid_q;

	logic      accept;
	logic      load_out;
	cell_ctl_t ctl;
	sel_t      sel;
	status_t   stat_d;
	cnt_t      count_d;
	logic      rd_en;
	logic      full;
	logic      empty;
	word_t     gathered;

	word_t words [CAPACITY];
	word_t taps  [CAPACITY];

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign load_out  = (state_q == S_LAST) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign full      = (count_q == cnt_t'(CAPACITY));
	assign empty     = (count_q == '0);

	always_comb begin
		ctl.act = ACT_HOLD;
		ctl.pos = position;
		ctl.val = value;
		stat_d  = ST_OK;
		count_d = count_q;
		rd_en   = 1'b0;
		unique case (kind)
			K_APPEND: begin
				ctl.pos = pos_t'(count_q);
				if (full) begin
					stat_d = ST_FULL;
				end else begin
					ctl.act = ACT_LOAD;
					count_d = count_q + cnt_t'(1);
				end
			end
			K_INSERT: begin
				if (position > pos_t'(count_q)) begin
					stat_d = ST_RANGE;
				end else if (full) begin
					stat_d = ST_FULL;
				end else begin
					ctl.act = ACT_INSERT;
					count_d = count_q + cnt_t'(1);
				end
			end
			K_REMOVE: begin
				if (empty)
					stat_d = ST_EMPTY;
				else
					count_d = count_q - cnt_t'(1);
			end
			K_ERASE: begin
				if (empty) begin
					stat_d = ST_EMPTY;
				end else if (position >= pos_t'(count_q)) begin
					stat_d = ST_RANGE;
				end else begin
					ctl.act = ACT_ERASE;
					count_d = count_q - cnt_t'(1);
				end
			end
			K_READ: begin
				if (empty)
					stat_d = ST_EMPTY;
				else if (position >= pos_t'(count_q))
					stat_d = ST_RANGE;
				else
					rd_en = 1'b1;
			end
			K_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
		if (!accept)
			ctl.act = ACT_HOLD;
	end

	// Steer the gather tree: read slot on accept, last slot until the result loads.
	always_comb begin
		if (state_q == S_READ || state_q == S_LAST) begin
			sel.en  = !empty;
			sel.pos = pos_t'(count_q - cnt_t'(1));
		end else begin
			sel.en  = accept && rd_en;
			sel.pos = position;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t left_w;
		word_t right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = words[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = words[i+1];
		end

		piel_cell u_cell (
			.clk        (clk),
			.idx        (idx_t'(i)),
			.ctl        (ctl),
			.sel        (sel),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (words[i]),
			.tap        (taps[i])
		);
	end

	piel_gather u_gather (
		.clk  (clk),
		.taps (taps),
		.word (gathered)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			stat_q      <= ST_OK;
			read_q      <= '0;
			out_valid_q <= 1'b0;
			status      <= '0;
			read_value  <= '0;
			entry_count <= '0;
			first_value <= '0;
			last_value  <= '0;
		end else begin
			if (out_valid_q && out_ready && !load_out)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= count_d;
						stat_q  <= stat_d;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					read_q  <= gathered;
					state_q <= S_LAST;
				end
				S_LAST: begin
					// hold until the previous result is taken
					if (load_out) begin
						status      <= stat_q;
						read_value  <= read_q;
						entry_count <= count_q;
						first_value <= empty ? word_t'(0) : words[0];
						last_value  <= empty ? word_t'(0) : gathered;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
